/* sv/tasf_pkg.sv */
// Shared types and constants of the two-axis averaging sample FIFO.
// Stands alone; every other file of the block but tasf_ram refers to it by scoped names.
`timescale 1ns / 1ps

package tasf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 5;
	localparam int REMAIN_W = 7;

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic STATUS_ENTRY = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	// One queued average with the time its block completed.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
		logic [TIME_W-1:0]          stamp;
	} entry_t;

endpackage

/* sv/tasf_cmd_if.sv */
// Command channel of the averaging sample FIFO: valid/ready plus one command beat.
// Depends on tasf_pkg for field widths.
`timescale 1ns / 1ps

interface tasf_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           command;
	logic signed [tasf_pkg::SAMPLE_W-1:0] sample_x;
	logic signed [tasf_pkg::SAMPLE_W-1:0] sample_y;
	logic [tasf_pkg::TIME_W-1:0]          time_stamp;
	logic [tasf_pkg::COUNT_W-1:0]         read_count;

	modport source (output valid, command, sample_x, sample_y, time_stamp, read_count,
		input ready);
	modport sink (input valid, command, sample_x, sample_y, time_stamp, read_count,
		output ready);
endinterface

/* sv/tasf_res_if.sv */
// Result channel of the averaging sample FIFO: valid/ready plus one result beat.
// Depends on tasf_pkg for field widths.
`timescale 1ns / 1ps

interface tasf_res_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 status;
	logic signed [tasf_pkg::SAMPLE_W-1:0] out_x;
	logic signed [tasf_pkg::SAMPLE_W-1:0] out_y;
	logic [tasf_pkg::TIME_W-1:0]          out_time;
	logic                                 overflow_seen;
	logic                                 last;
	logic [tasf_pkg::REMAIN_W-1:0]        remaining;

	modport source (output valid, status, out_x, out_y, out_time, overflow_seen, last,
		remaining, input ready);
	modport sink (input valid, status, out_x, out_y, out_time, overflow_seen, last,
		remaining, output ready);
endinterface

/* sv/tasf_ram.sv */
// Simple dual-port entry store of the sample FIFO, one write and one registered read.
// No package dependency; the width is set by the instantiating module.
`timescale 1ns / 1ps

module tasf_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/tasf_accum.sv */
// Block accumulator: sums 2^AVG_LOG2 sample pairs and hands out the rounded average.
// Depends on tasf_pkg for the entry type and field widths.
`timescale 1ns / 1ps

module tasf_accum #(
	parameter int AVG_LOG2 = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 clear,
	input  logic signed [tasf_pkg::SAMPLE_W-1:0] sample_x,
	input  logic signed [tasf_pkg::SAMPLE_W-1:0] sample_y,
	input  logic [tasf_pkg::TIME_W-1:0]          time_stamp,
	output logic                                 entry_valid,
	output tasf_pkg::entry_t                     entry
);

	localparam int SW    = tasf_pkg::SAMPLE_W;
	localparam int SUM_W = SW + AVG_LOG2;
	localparam logic signed [SW-1:0] AVG_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] AVG_MIN = {1'b1, {(SW-1){1'b0}}};

	logic [AVG_LOG2-1:0]             cnt_q;
	logic signed [SUM_W-1:0]         sum_x_q, sum_y_q;
	logic signed [SUM_W-1:0]         next_x, next_y;
	logic                            done_s1;
	logic signed [SUM_W-1:0]         sum_x_s1, sum_y_s1;
	logic [tasf_pkg::TIME_W-1:0]     stamp_s1;
	logic                            block_done;

	// Arithmetic shift, round half up on the top dropped bit, clamp to the sample range.
	function automatic logic signed [SW-1:0] block_avg(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] q;
		logic signed [SW:0]      r;
		q = s >>> AVG_LOG2;
		r = (SW+1)'(q) + $signed({{SW{1'b0}}, s[AVG_LOG2-1]});
		if (r[SW:SW-1] == 2'b01) begin
			return AVG_MAX;
		end else if (r[SW:SW-1] == 2'b10) begin
			return AVG_MIN;
		end
		return $signed(r[SW-1:0]);
	endfunction

	assign next_x     = sum_x_q + SUM_W'(sample_x);
	assign next_y     = sum_y_q + SUM_W'(sample_y);
	assign block_done = &cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= push && block_done;
			if (clear) begin
				cnt_q   <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
			end else if (push) begin
				cnt_q <= cnt_q + AVG_LOG2'(1);
				if (block_done) begin
					sum_x_q <= '0;
					sum_y_q <= '0;
				end else begin
					sum_x_q <= next_x;
					sum_y_q <= next_y;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && block_done) begin
			sum_x_s1 <= next_x;
			sum_y_s1 <= next_y;
			stamp_s1 <= time_stamp;
		end
	end

	assign entry_valid = done_s1;
	assign entry.x     = block_avg(sum_x_s1);
	assign entry.y     = block_avg(sum_y_s1);
	assign entry.stamp = stamp_s1;

endmodule

/* sv/two_axis_average_sample_fifo.sv */
// Top level of the two-axis averaging sample FIFO: command decode, ring pointers,
// read sequencer and result register. Uses tasf_pkg, tasf_cmd_if, tasf_res_if,
// tasf_accum and tasf_ram.
`timescale 1ns / 1ps

// Push beats carry one signed sample pair; every 2^AVG_LOG2 pushes the per-axis sums
// are averaged (arithmetic shift, rounded half up) and queued with that push's time
// stamp in a ring of FIFO_DEPTH entries held in one synchronous memory. A full ring
// overwrites its oldest entry and sets the sticky overflow flag, which only reset
// clears. A read beat pops up to read_count entries (at most MAX_READ_BURST), one
// result per cycle while results.ready allows, oldest first, the final one marked with
// last; a read of an empty ring gives a single result with status set. A clear beat
// empties the ring and the partial block. Timing: the push that completes a block
// holds off beats in the cycle that follows it, while the average is written into
// the memory. A read beat enters the read sequencer, which issues one memory read per
// cycle unless the result path is stalled; each result passes through the registered
// memory port and then the result register, and no new beat is accepted until
// the sequencer has issued the final read of the burst. A read of count zero and the
// unused command code are accepted and produce nothing. The memory needs no clearing
// after reset, since only written entries are ever read. capture_enable resets to 1;
// while it is 0, completed blocks are dropped.
module two_axis_average_sample_fifo #(
	parameter int FIFO_DEPTH     = 64,
	parameter int AVG_LOG2       = 3,
	parameter int MAX_READ_BURST = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	tasf_cmd_if.sink   samples,
	tasf_res_if.source results
);

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int FW = $clog2(FIFO_DEPTH + 1);
	localparam int BW = $clog2(MAX_READ_BURST + 1);
	localparam int NW0 = (FW > BW) ? FW : BW;
	localparam int NW = (NW0 > tasf_pkg::COUNT_W) ? NW0 : tasf_pkg::COUNT_W;
	localparam int EW = $bits(tasf_pkg::entry_t);

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;

	logic             capture_enable_q;
	logic             overflow_q;
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [FW-1:0]    fill_q;
	logic [BW-1:0]    left_q;
	logic             empty_q;

	// The accumulator hands over a finished average for one cycle.
	logic             entry_valid;
	tasf_pkg::entry_t entry;
	logic             push_en;

	// Handshake and command decode.
	logic             accept;
	logic             cmd_push, cmd_read, cmd_clear;

	// Burst length of an accepted read.
	logic [NW-1:0]    rc_n, want_n, fill_n, take_n;

	// Read issue stage: memory read in flight or its data held while stalled.
	logic             issue;
	logic             out_free;
	logic             valid_s1;
	logic             status_s1, last_s1, ovf_s1;
	logic [tasf_pkg::REMAIN_W-1:0] remaining_s1;
	logic [EW-1:0]    ram_rdata;
	tasf_pkg::entry_t rd_entry;

	// Result register.
	logic             res_valid_q;
	logic             res_status_q, res_last_q, res_ovf_q;
	logic signed [tasf_pkg::SAMPLE_W-1:0] res_x_q, res_y_q;
	logic [tasf_pkg::TIME_W-1:0]          res_time_q;
	logic [tasf_pkg::REMAIN_W-1:0]        res_remaining_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	// No beat is taken while a burst is being issued or while a finished average is
	// written; this keeps memory writes and pointer updates apart from reads.
	assign samples.ready = (state_q == ST_IDLE) && !entry_valid;
	assign accept        = samples.valid && samples.ready;
	assign cmd_push      = accept && (samples.command == tasf_pkg::CMD_PUSH);
	assign cmd_read      = accept && (samples.command == tasf_pkg::CMD_READ);
	assign cmd_clear     = accept && (samples.command == tasf_pkg::CMD_CLEAR);

	assign push_en = entry_valid && capture_enable_q;

	tasf_accum #(
		.AVG_LOG2(AVG_LOG2)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.clear      (cmd_clear),
		.sample_x   (samples.sample_x),
		.sample_y   (samples.sample_y),
		.time_stamp (samples.time_stamp),
		.entry_valid(entry_valid),
		.entry      (entry)
	);

	// The number of pops is min(fill, saturated count), fixed when the read is taken.
	always_comb begin
		rc_n   = NW'(samples.read_count);
		want_n = (rc_n > NW'(MAX_READ_BURST)) ? NW'(MAX_READ_BURST) : rc_n;
		fill_n = NW'(fill_q);
		take_n = (fill_n < want_n) ? fill_n : want_n;
	end

	assign out_free = !res_valid_q || results.ready;
	assign issue    = (state_q == ST_READ) && (!valid_s1 || out_free);

	tasf_ram #(
		.DEPTH(FIFO_DEPTH),
		.WIDTH(EW)
	) u_ram (
		.clk  (clk),
		.we   (push_en),
		.waddr(wptr_q),
		.wdata(entry),
		.re   (issue && !empty_q),
		.raddr(rptr_q),
		.rdata(ram_rdata)
	);

	assign rd_entry = tasf_pkg::entry_t'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			capture_enable_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			overflow_q  <= 1'b0;
			wptr_q      <= '0;
			rptr_q      <= '0;
			fill_q      <= '0;
			left_q      <= '0;
			empty_q     <= 1'b0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (push_en) begin
				wptr_q <= next_ptr(wptr_q);
				if (fill_q == FW'(FIFO_DEPTH)) begin
					// Full: the oldest entry is lost to the new one.
					overflow_q <= 1'b1;
					rptr_q     <= next_ptr(rptr_q);
				end else begin
					fill_q <= fill_q + FW'(1);
				end
			end
			if (cmd_clear) begin
				wptr_q <= '0;
				rptr_q <= '0;
				fill_q <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_read && (samples.read_count != '0)) begin
						state_q <= ST_READ;
						empty_q <= (fill_q == '0);
						left_q  <= (fill_q == '0) ? BW'(1) : BW'(take_n);
					end
				end
				ST_READ: begin
					if (issue) begin
						left_q <= left_q - BW'(1);
						if (!empty_q) begin
							rptr_q <= next_ptr(rptr_q);
							fill_q <= fill_q - FW'(1);
						end
						if (left_q == BW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	// Side fields travel with the memory read.
	always_ff @(posedge clk) begin
		if (issue) begin
			status_s1    <= empty_q ? tasf_pkg::STATUS_EMPTY : tasf_pkg::STATUS_ENTRY;
			last_s1      <= (left_q == BW'(1));
			ovf_s1       <= overflow_q;
			remaining_s1 <= empty_q ? '0 : tasf_pkg::REMAIN_W'(fill_q - FW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			res_status_q    <= status_s1;
			res_last_q      <= last_s1;
			res_ovf_q       <= ovf_s1;
			res_remaining_q <= remaining_s1;
			if (status_s1 == tasf_pkg::STATUS_EMPTY) begin
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_time_q <= '0;
			end else begin
				res_x_q    <= rd_entry.x;
				res_y_q    <= rd_entry.y;
				res_time_q <= rd_entry.stamp;
			end
		end
	end

	assign results.valid         = res_valid_q;
	assign results.status        = res_status_q;
	assign results.out_x         = res_x_q;
	assign results.out_y         = res_y_q;
	assign results.out_time      = res_time_q;
	assign results.overflow_seen = res_ovf_q;
	assign results.last          = res_last_q;
	assign results.remaining     = res_remaining_q;

	// The fill count never passes the ring size.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(FIFO_DEPTH))
		else $error("fill count above ring depth");

	// An empty or full ring has its pointers on the same entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == FW'(FIFO_DEPTH)) |-> (wptr_q == rptr_q))
		else $error("ring pointers disagree with fill count");

	// A memory write never meets a memory read of a burst.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push_en && issue))
		else $error("push write overlaps burst read");

	// Issuing the final read of a burst returns the sequencer to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(issue && left_q == BW'(1)) |=> (state_q == ST_IDLE))
		else $error("burst did not end after its final read");

	// An empty report is always a lone, final result with nothing remaining.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q == tasf_pkg::STATUS_EMPTY)
			|-> (res_last_q && res_remaining_q == '0))
		else $error("empty report malformed");

endmodule
